// ----- design/puoo_pkg.sv -----
// Package for the permutation unrank operator order unit.
// Holds the input and result word types and fixed constants; no dependencies.
package puoo_pkg;

  localparam int RANK_W     = 63;
  localparam int NSIZE_W    = 5;
  localparam int OPVAL_W    = 5;
  localparam int POS_W      = 4;
  localparam int BIT_W      = $clog2(RANK_W);
  localparam int FLIP_BASE  = 2;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [NSIZE_W-1:0] stack_size;
  } in_t;

  typedef struct packed {
    logic [OPVAL_W-1:0] operator_value;
    logic [POS_W-1:0]   position;
    logic               last;
  } out_t;

endpackage

// ----- design/permutation_unrank_operator_order_unit.sv -----
// Permutation unrank operator order unit: turns a rank into an ordering of the
// flip operators 2..n by factorial-base unranking. Depends on puoo_pkg.
//
// Operation: an item with stack size n (saturated to MAX_STACK) has its n-1 digits
// worked out one after another in a one-bit-per-cycle restoring divider. Once the
// last digit is final, the n-1 results follow on consecutive cycles, and busy
// stays high from acceptance until the final result. A new word is accepted only
// while idle. A stack size below two yields no result and leaves the unit idle.
// The receiver cannot stall: each result is shown once.
// Reset (asynchronous, active low) returns the sequencer to idle and drops
// the result strobe; digit and datapath registers are not reset.
module permutation_unrank_operator_order_unit #(
  parameter int MAX_STACK = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  puoo_pkg::in_t  in_i,
  output logic           valid_o,
  output puoo_pkg::out_t out_o
);
  import puoo_pkg::*;

  // Number of digits at most, width of a digit or radix, width of a digit index.
  localparam int NDIG = MAX_STACK - 1;
  localparam int DW   = $clog2(MAX_STACK);
  localparam int IW   = $clog2(NDIG);
  localparam int SW   = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [RANK_W-1:0] quot_q;
  logic [DW-1:0]     rem_q;
  logic [DW-1:0]     radix_q;
  logic [BIT_W-1:0]  bit_q;
  logic [IW-1:0]     x_q;
  logic [IW-1:0]     last_q;
  logic [IW-1:0]     pos_q;
  logic [DW-1:0]     dig_q [NDIG];
  logic              valid_q;
  out_t              out_q;

  // Input decode: saturate the stack size and find the index of the final digit.
  logic [SW-1:0] nsat;
  logic [SW-1:0] nsat_m2;
  logic          accept;
  logic          too_small;

  always_comb begin
    nsat = {{(SW-NSIZE_W){1'b0}}, in_i.stack_size};
    if (nsat > SW'(MAX_STACK)) begin
      nsat = SW'(MAX_STACK);
    end
    nsat_m2   = nsat - SW'(2);
    too_small = (nsat < SW'(2));
    accept    = start && (state_q == ST_IDLE);
  end

  // The shared divider step: shift one quotient bit into the partial remainder,
  // subtract the radix when it fits.
  logic [DW:0]       shifted;
  logic              fits;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_next;
  logic [RANK_W-1:0] quot_next;
  logic              digit_done;

  always_comb begin
    shifted    = {rem_q, quot_q[RANK_W-1]};
    fits       = (shifted >= {1'b0, radix_q});
    diff       = shifted - {1'b0, radix_q};
    rem_next   = fits ? diff[DW-1:0] : shifted[DW-1:0];
    quot_next  = {quot_q[RANK_W-2:0], fits};
    digit_done = (bit_q == BIT_W'(RANK_W - 1));
  end

  // Once a digit is final, it is placed at its position and every later digit
  // at least as large moves up by one.
  logic [DW-1:0] dig_bumped [NDIG];

  always_comb begin
    for (int y = 0; y < NDIG; y++) begin
      dig_bumped[y] = dig_q[y];
      if (IW'(y) == x_q) begin
        dig_bumped[y] = rem_next;
      end else if ((IW'(y) > x_q) && (IW'(y) <= last_q) && (dig_q[y] >= rem_next)) begin
        dig_bumped[y] = dig_q[y] + DW'(1);
      end
    end
  end

  // Result formatting from the digit at the head of the shift line.
  logic [DW+OPVAL_W:0] opval_wide;
  logic [IW+POS_W-1:0] pos_wide;

  always_comb begin
    opval_wide = {{(OPVAL_W+1){1'b0}}, dig_q[0]} + (DW+OPVAL_W+1)'(FLIP_BASE);
    pos_wide   = {{POS_W{1'b0}}, pos_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && !too_small) begin
            quot_q  <= in_i.rank;
            rem_q   <= '0;
            radix_q <= DW'(1);
            bit_q   <= '0;
            last_q  <= nsat_m2[IW-1:0];
            x_q     <= nsat_m2[IW-1:0];
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (digit_done) begin
            // Quotient becomes the rank for the next, wider radix.
            for (int y = 0; y < NDIG; y++) begin
              dig_q[y] <= dig_bumped[y];
            end
            quot_q     <= quot_next;
            rem_q      <= '0;
            radix_q    <= radix_q + DW'(1);
            bit_q      <= '0;
            if (x_q == '0) begin
              pos_q   <= '0;
              state_q <= ST_EMIT;
            end else begin
              x_q <= x_q - IW'(1);
            end
          end else begin
            quot_q <= quot_next;
            rem_q  <= rem_next;
            bit_q  <= bit_q + BIT_W'(1);
          end
        end
        ST_EMIT: begin
          valid_q              <= 1'b1;
          out_q.operator_value <= opval_wide[OPVAL_W-1:0];
          out_q.position       <= pos_wide[POS_W-1:0];
          out_q.last           <= (pos_q == last_q);
          for (int y = 0; y < NDIG - 1; y++) begin
            dig_q[y] <= dig_q[y+1];
          end
          pos_q <= pos_q + IW'(1);
          if (pos_q == last_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ----- design/puoo_checker.sv -----
// Port-level checker for the permutation unrank operator order unit.
// Depends on puoo_pkg; bound to the top level at the end of this file.
module puoo_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input puoo_pkg::in_t  in_i,
  input logic           valid_o,
  input puoo_pkg::out_t out_o
);
  import puoo_pkg::*;

  // An accepted word with at least two pancakes keeps the unit busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.stack_size >= NSIZE_W'(2))) |=> busy)
    else $error("unit not busy after accepting a word");

  // Until the final result, the unit stays busy.
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.last) |-> busy)
    else $error("unit idle in the middle of an ordering");

  // Results of one ordering come on consecutive cycles with rising positions.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.last) |=>
      (valid_o && (out_o.position == POS_W'($past(out_o.position) + POS_W'(1)))))
    else $error("result burst broken or position skipped");

  // Each ordering starts at position zero.
  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (out_o.position == '0))
    else $error("ordering does not start at position zero");

endmodule

bind permutation_unrank_operator_order_unit puoo_checker u_puoo_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .in_i    (in_i),
  .valid_o (valid_o),
  .out_o   (out_o)
);

// ----- bench/tb_permutation_unrank_operator_order_unit.sv -----
// Self-checking testbench for the permutation unrank operator order unit.
// It depends on puoo_pkg and the unit's RTL. A directed table runs first, then random words,
// and every result is checked against a predictor built into the bench.
module tb_permutation_unrank_operator_order_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import puoo_pkg::*;

  localparam int MAX_STACK   = 16;
  localparam int RANDOM_WORDS = 350;
  // The slowest correct run is about 400 words at the largest stack size, plus gaps and drains.
  // The limit is several times the length of that run.
  localparam int CYCLE_LIMIT = 1_500_000;
  // One full item at the largest stack size, plus a margin.
  localparam int TAIL_CYCLES = 64 * MAX_STACK + 64;
  localparam int PRINT_CAP   = 40;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [RANK_W-1:0] FACT15   = 63'd1307674368000;

  // This is how the expected results of a table row are obtained. FORM_PRED asks the
  // predictor. The other forms are typed in because they can be read off directly:
  // rank 0, or any rank that is a multiple of (n-1)!, gives the operators 2..n in order.
  // Rank (n-1)!-1 gives them reversed. A stack size below two gives nothing.
  typedef enum logic [1:0] {FORM_PRED, FORM_NONE, FORM_IDENT, FORM_REVERSE} form_e;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [NSIZE_W-1:0] stack_size;
    form_e              form;
  } stim_row_t;

  localparam int N_ROWS = 23;
  localparam stim_row_t STIM_TABLE [N_ROWS] = '{
    '{63'd0,                    5'd2,  FORM_IDENT},    // smallest stack, one operator
    '{RANK_MAX,                 5'd2,  FORM_IDENT},    // radix 1 swallows any rank
    '{63'd1,                    5'd2,  FORM_IDENT},
    '{63'd0,                    5'd0,  FORM_NONE},     // small stack: no operator at all
    '{RANK_MAX,                 5'd1,  FORM_NONE},
    '{63'd0,                    5'd16, FORM_IDENT},    // largest stack, first ordering
    '{FACT15 - 63'd1,           5'd16, FORM_REVERSE},  // largest stack, last ordering
    '{FACT15,                   5'd16, FORM_IDENT},    // rank wraps at (n-1)!
    '{63'd0,                    5'd31, FORM_IDENT},    // large stack saturates to MAX_STACK
    '{FACT15 - 63'd1,           5'd17, FORM_REVERSE},
    '{RANK_MAX,                 5'd16, FORM_PRED},
    '{RANK_MAX,                 5'd31, FORM_PRED},
    '{63'd1,                    5'd3,  FORM_REVERSE},
    '{63'd5,                    5'd4,  FORM_REVERSE},
    '{63'd6,                    5'd4,  FORM_IDENT},
    '{63'd23,                   5'd5,  FORM_REVERSE},
    '{63'd119,                  5'd6,  FORM_REVERSE},
    '{63'd1,                    5'd16, FORM_PRED},
    '{63'h4000_0000_0000_0000,  5'd16, FORM_PRED},     // top rank bit alone
    '{63'h5555_5555_5555_5555,  5'd10, FORM_PRED},
    '{63'h2AAA_AAAA_AAAA_AAAA,  5'd9,  FORM_PRED},
    '{63'd12345,                5'd8,  FORM_PRED},
    '{63'd1000,                 5'd7,  FORM_PRED}
  };

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic valid_o;
  out_t out_o;

  // Expected result words, oldest first.
  out_t pending_ops [$];
  int   mismatches = 0;
  int   cycle_count = 0;

  permutation_unrank_operator_order_unit #(
    .MAX_STACK(MAX_STACK)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .out_o  (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog. A hung unit or a lost handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Saturates the stack size the way the unit does and returns the number of operators.
  function automatic int operator_count(input logic [NSIZE_W-1:0] stack_size);
    int n;
    n = stack_size;
    if (n < 2) return 0;
    if (n > MAX_STACK) n = MAX_STACK;
    return n - 1;
  endfunction

  // Factorial-base unranking. Positions are filled from the last one down. Each new digit
  // is the remainder of the rank by a radix that grows by one per position. Each later digit
  // at or above the new digit then moves up by one, so the digits stay distinct.
  function automatic void unrank_operators(input logic [RANK_W-1:0] rank,
                                           input logic [NSIZE_W-1:0] stack_size);
    logic [63:0] digit [MAX_STACK];
    logic [63:0] remaining;
    logic [63:0] radix;
    int          cnt;
    int          k;
    int          j;
    out_t        w;
    cnt = operator_count(stack_size);
    remaining = {1'b0, rank};
    radix = 64'd1;
    for (k = 0; k < MAX_STACK; k++) digit[k] = '0;
    for (k = cnt - 1; k >= 0; k--) begin
      digit[k] = remaining % radix;
      remaining = remaining / radix;
      radix = radix + 64'd1;
      for (j = k + 1; j < cnt; j++) begin
        if (digit[j] >= digit[k]) digit[j] = digit[j] + 64'd1;
      end
    end
    for (k = 0; k < cnt; k++) begin
      w.operator_value = OPVAL_W'(digit[k] + FLIP_BASE);
      w.position       = POS_W'(k);
      w.last           = (k == cnt - 1);
      pending_ops = {pending_ops, w};
    end
  endfunction

  // Queues results that are typed in: operators 2..n in order, or reversed.
  function automatic void queue_fixed_order(input logic [NSIZE_W-1:0] stack_size,
                                            input bit reversed);
    int   cnt;
    int   k;
    out_t w;
    cnt = operator_count(stack_size);
    for (k = 0; k < cnt; k++) begin
      w.operator_value = OPVAL_W'(reversed ? cnt + 1 - k : k + 2);
      w.position       = POS_W'(k);
      w.last           = (k == cnt - 1);
      pending_ops = {pending_ops, w};
    end
  endfunction

  function automatic logic [63:0] factorial(input int m);
    logic [63:0] f;
    int          k;
    f = 64'd1;
    for (k = 2; k <= m; k++) f = f * k;
    return f;
  endfunction

  // Presents one word and holds it until the unit takes it. The unit takes the word at an
  // edge where start is high and busy is low. This is called at a rising edge. It returns at
  // the edge of acceptance, with start still high.
  task automatic send_word(input logic [RANK_W-1:0] rank, input logic [NSIZE_W-1:0] stack_size,
                           input form_e form);
    start <= 1'b1;
    in_i.rank <= rank;
    in_i.stack_size <= stack_size;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (form)
      FORM_PRED: begin
        unrank_operators(rank, stack_size);
      end
      FORM_IDENT: begin
        queue_fixed_order(stack_size, 1'b0);
      end
      FORM_REVERSE: begin
        queue_fixed_order(stack_size, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  // Drops start for a number of cycles. It is called only right after an acceptance, so
  // start is never lowered and raised in the same step.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Lowers start and waits until every expected result has come back.
  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_ops.size() != 0) @(posedge clk_i);
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a word to check against the
  // oldest expectation. Outputs are sampled at the rising edge, before the unit updates them.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_ops.size() == 0) begin
        report_mismatch($sformatf("unexpected word op=%0d pos=%0d last=%0d",
                                  out_o.operator_value, out_o.position, out_o.last));
      end else begin
        want = pending_ops.pop_front();
        if (out_o.operator_value !== want.operator_value || out_o.position !== want.position ||
            out_o.last !== want.last) begin
          report_mismatch($sformatf("got op=%0d pos=%0d last=%0d, want op=%0d pos=%0d last=%0d",
                                    out_o.operator_value, out_o.position, out_o.last,
                                    want.operator_value, want.position, want.last));
        end
      end
    end
  end

  // Stimulus. The directed table runs first and the random words follow. The sender works in
  // bursts of random length. Between bursts come random gaps, and now and then a full drain.
  // Busy periods depend on the stack size, so the gaps end at every phase of the unit's work.
  initial begin
    int                 row;
    int                 accepted;
    int                 burst_left;
    int                 cnt;
    int                 pick;
    logic [NSIZE_W-1:0] size;
    logic [RANK_W-1:0]  rank;
    logic [63:0]        fact;

    start  = 1'b0;
    in_i   = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A short gap follows every fourth row, so that both back-to-back and
    // spaced words are seen.
    for (row = 0; row < N_ROWS; row++) begin
      send_word(STIM_TABLE[row].rank, STIM_TABLE[row].stack_size, STIM_TABLE[row].form);
      if (row % 4 == 3) hold_off($urandom_range(1, 5));
    end
    // The sender pauses here until everything is back, so the unit then starts from idle.
    drain_results();

    // Random part. Only words that produce results count toward the total. Stack sizes below
    // two are mixed in as noise.
    accepted   = 0;
    burst_left = $urandom_range(1, 8);
    while (accepted < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) size = NSIZE_W'($urandom_range(0, 1));
      else if (pick < 16) size = NSIZE_W'($urandom_range(MAX_STACK + 1, 31));
      else size = NSIZE_W'($urandom_range(2, MAX_STACK));
      cnt  = operator_count(size);
      fact = factorial(cnt);
      case ($urandom_range(0, 3))
        0: rank = RANK_W'({$urandom(), $urandom()});
        1: rank = RANK_W'($urandom_range(0, 200));
        // Around the wrap point of the rank: (n-1)!-1, (n-1)! and (n-1)!+1.
        2: rank = RANK_W'(fact - 64'd1 + 64'($urandom_range(0, 2)));
        default: rank = RANK_W'({1'b0, $urandom(), $urandom()} % {1'b0, fact});
      endcase
      send_word(rank, size, FORM_PRED);
      if (cnt > 0) accepted++;

      burst_left--;
      if ($urandom_range(0, 39) == 0) begin
        drain_results();
      end else if (burst_left <= 0) begin
        // Mostly short bursts. Now and then a long stretch with no idling.
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        hold_off($urandom_range(1, 12));
      end
    end

    // Wait for every expected word. Then give the unit one more full item's time, so that any
    // stray strobe would still be caught.
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/puoo_pkg.sv
design/permutation_unrank_operator_order_unit.sv
design/puoo_checker.sv
bench/tb_permutation_unrank_operator_order_unit.sv
